### sv/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg: shared types and constants of the tracker frame checker
// Field widths, report codes, header offsets, the queue entry type and
// the table-form CRC-16/ARC step.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 32;
    localparam int DECL_W    = 33;
    localparam int CRC_W     = 16;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int LANE_W    = 2;
    localparam int TAIL_N    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Header layout in byte offsets.
    localparam int PRE_END        = 4;
    localparam int LEN_END        = 8;
    localparam int FRAME_START    = 12;
    localparam int FRAME_END      = 16;
    localparam int SENS_START     = 20;
    localparam int SENS_END       = 24;
    localparam int CRC_START      = 4;
    localparam int MIN_FRAME_BYTES = 8;
    localparam logic [DECL_W-1:0] LENGTH_BIAS = 33'd8;

    localparam logic [KIND_W-1:0] KIND_PNO     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CMD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LENGTH = 2'd1;
    localparam logic [STAT_W-1:0] STAT_CRC    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PNO_PREAMBLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_PREAMBLE = 1'b1;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_PREAMBLE,
        FLD_LENGTH,
        FLD_FRAME,
        FLD_SENSORS
    } t_field;

    // One classified byte on its way from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        t_field            field;
        logic [LANE_W-1:0] lane;
        logic              crc_en;
    } t_entry;

    // Entry of the 256-word reflected CRC table; a constant function of idx.
    function automatic logic [CRC_W-1:0] crc_table_entry(input logic [BYTE_W-1:0] idx);
        logic [CRC_W-1:0] c;
        c = {8'h00, idx};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] crc_arc_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] t;
        t = crc_table_entry(crc[BYTE_W-1:0] ^ b);
        return {8'h00, crc[CRC_W-1:BYTE_W]} ^ t;
    endfunction

endpackage

### sv/tfc_queue.sv
// ----------------------------------------------------------------------------
// tfc_queue: two-entry queue between front and back
// Decouples the byte intake from the checking side so that each can stall
// on its own; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tfc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [W-1:0]      r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr   = i_push ? r_wr + 1'b1 : r_wr;
        n_rd   = i_pop ? r_rd + 1'b1 : r_rd;
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

### sv/tfc_front.sv
// ----------------------------------------------------------------------------
// tfc_front: byte intake and classification
// Counts the bytes of a transfer and tags each byte with the header word
// and lane it belongs to and whether it feeds the CRC.
// ----------------------------------------------------------------------------
module tfc_front #(
    parameter int MAX_TRANSFER_BYTES = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic [tfc_pkg::BYTE_W-1:0]            i_data_byte,
    input  logic                                  i_last_byte,
    input  logic                                  i_q_full,
    output logic                                  o_in_stall,
    output logic                                  o_push,
    output tfc_pkg::t_entry                       o_entry,
    output logic [$clog2(MAX_TRANSFER_BYTES+2)-1:0] o_count
);
    import tfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRANSFER_BYTES + 2);

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] count_inc;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // The count stops one past the maximum so that an overrun stays visible.
    assign count_inc = (r_count <= CNT_W'(MAX_TRANSFER_BYTES)) ? r_count + 1'b1 : r_count;
    assign o_count   = count_inc;

    always_comb begin
        o_entry.data   = i_data_byte;
        o_entry.last   = i_last_byte;
        o_entry.lane   = r_count[LANE_W-1:0];
        o_entry.crc_en = (r_count >= CNT_W'(CRC_START));
        if (r_count < CNT_W'(PRE_END)) begin
            o_entry.field = FLD_PREAMBLE;
        end else if (r_count < CNT_W'(LEN_END)) begin
            o_entry.field = FLD_LENGTH;
        end else if (r_count >= CNT_W'(FRAME_START) && r_count < CNT_W'(FRAME_END)) begin
            o_entry.field = FLD_FRAME;
        end else if (r_count >= CNT_W'(SENS_START) && r_count < CNT_W'(SENS_END)) begin
            o_entry.field = FLD_SENSORS;
        end else begin
            o_entry.field = FLD_NONE;
        end

        n_count = r_count;
        if (o_push) begin
            n_count = i_last_byte ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### sv/tfc_back.sv
// ----------------------------------------------------------------------------
// tfc_back: header capture, CRC and report
// Assembles the header words, runs the tail delay line into the CRC and,
// on the last byte, loads the checked report into the output register.
// ----------------------------------------------------------------------------
module tfc_back #(
    parameter int MAX_TRANSFER_BYTES = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_q_valid,
    input  tfc_pkg::t_entry                         i_entry,
    input  logic [$clog2(MAX_TRANSFER_BYTES+2)-1:0] i_count,
    output logic                                    o_pop,
    input  logic [tfc_pkg::WORD_W-1:0]              i_pno_preamble,
    input  logic [tfc_pkg::WORD_W-1:0]              i_cmd_preamble,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [tfc_pkg::KIND_W-1:0]              o_frame_kind,
    output logic [tfc_pkg::STAT_W-1:0]              o_check_status,
    output logic [$clog2(MAX_TRANSFER_BYTES+1)-1:0] o_byte_count,
    output logic [tfc_pkg::DECL_W-1:0]              o_declared_length,
    output logic [tfc_pkg::WORD_W-1:0]              o_frame_number,
    output logic [tfc_pkg::WORD_W-1:0]              o_sensor_count,
    output logic [tfc_pkg::CRC_W-1:0]               o_computed_crc,
    output logic [tfc_pkg::WORD_W-1:0]              o_carried_crc
);
    import tfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRANSFER_BYTES + 2);
    localparam int BC_W  = $clog2(MAX_TRANSFER_BYTES + 1);

    logic [WORD_W-1:0]             r_pre, n_pre, u_pre;
    logic [WORD_W-1:0]             r_len, n_len, u_len;
    logic [WORD_W-1:0]             r_frame, n_frame, u_frame;
    logic [WORD_W-1:0]             r_sens, n_sens, u_sens;
    logic [CRC_W-1:0]              r_crc, n_crc, u_crc;
    logic [TAIL_N-1:0][BYTE_W-1:0] r_tail, n_tail, u_tail;
    logic                          r_out_valid, n_out_valid;
    logic                          finish;

    logic [KIND_W-1:0] rep_kind;
    logic [STAT_W-1:0] rep_status;
    logic [BC_W-1:0]   rep_count;
    logic [DECL_W-1:0] rep_declared;
    logic              overrun;

    // A last byte waits until the output register is free or being emptied.
    assign o_pop  = i_q_valid && (!i_entry.last || !r_out_valid || !i_out_stall);
    assign finish = o_pop && i_entry.last;
    assign o_out_valid = r_out_valid;

    always_comb begin
        u_pre   = r_pre;
        u_len   = r_len;
        u_frame = r_frame;
        u_sens  = r_sens;
        u_crc   = r_crc;
        u_tail  = r_tail;
        if (o_pop) begin
            case (i_entry.field)
                FLD_PREAMBLE: u_pre[i_entry.lane*BYTE_W +: BYTE_W]   = i_entry.data;
                FLD_LENGTH:   u_len[i_entry.lane*BYTE_W +: BYTE_W]   = i_entry.data;
                FLD_FRAME:    u_frame[i_entry.lane*BYTE_W +: BYTE_W] = i_entry.data;
                FLD_SENSORS:  u_sens[i_entry.lane*BYTE_W +: BYTE_W]  = i_entry.data;
                default: ;
            endcase
            // The byte leaving the delay line is the one that enters the CRC.
            if (i_entry.crc_en) begin
                u_crc = crc_arc_byte(r_crc, r_tail[0]);
            end
            u_tail = {i_entry.data, r_tail[TAIL_N-1:1]};
        end

        overrun      = (i_count > CNT_W'(MAX_TRANSFER_BYTES));
        rep_count    = overrun ? BC_W'(MAX_TRANSFER_BYTES) : i_count[BC_W-1:0];
        rep_declared = {1'b0, u_len} + LENGTH_BIAS;

        if (i_count < CNT_W'(MIN_FRAME_BYTES)) begin
            rep_kind = KIND_UNKNOWN;
        end else if (u_pre == i_pno_preamble) begin
            rep_kind = KIND_PNO;
        end else if (u_pre == i_cmd_preamble) begin
            rep_kind = KIND_CMD;
        end else begin
            rep_kind = KIND_UNKNOWN;
        end

        if (rep_kind == KIND_UNKNOWN) begin
            rep_status = STAT_OK;
        end else if (overrun || rep_declared != DECL_W'(i_count)) begin
            rep_status = STAT_LENGTH;
        end else if (u_tail != {16'h0000, u_crc}) begin
            rep_status = STAT_CRC;
        end else begin
            rep_status = STAT_OK;
        end

        // The transfer state starts over after each last byte.
        if (finish) begin
            n_pre   = '0;
            n_len   = '0;
            n_frame = '0;
            n_sens  = '0;
            n_crc   = '0;
            n_tail  = '0;
        end else begin
            n_pre   = u_pre;
            n_len   = u_len;
            n_frame = u_frame;
            n_sens  = u_sens;
            n_crc   = u_crc;
            n_tail  = u_tail;
        end

        if (finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre       <= '0;
            r_len       <= '0;
            r_frame     <= '0;
            r_sens      <= '0;
            r_crc       <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pre       <= n_pre;
            r_len       <= n_len;
            r_frame     <= n_frame;
            r_sens      <= n_sens;
            r_crc       <= n_crc;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_frame_kind      <= rep_kind;
            o_check_status    <= rep_status;
            o_byte_count      <= rep_count;
            o_declared_length <= rep_declared;
            o_frame_number    <= u_frame;
            o_sensor_count    <= u_sens;
            o_computed_crc    <= u_crc;
            o_carried_crc     <= u_tail;
        end
    end

endmodule

### sv/tracker_frame_checker_core.sv
// ----------------------------------------------------------------------------
// tracker_frame_checker_core: framing, length and CRC check of a transfer
// Bytes of one bulk transfer enter on the input channel (i_in_valid,
// o_in_stall), one per cycle, with i_last_byte set on the final byte.
// A transfer takes place at an edge with valid high and stall low.
// The front counts and classifies bytes and hands them through a
// two-entry queue to the back, which assembles the header words and runs
// CRC-16/ARC (one table lookup per byte) over all but the last four bytes.
// A transfer's single report is registered onto o_out_valid when its last
// byte is popped. If the receiver holds i_out_stall, the report stays in
// the output register, the back keeps working on following non-last bytes,
// and only the next last byte waits; the queue then fills and o_in_stall
// rises. Preamble registers are written on the configuration channel
// (i_cfg_valid, o_cfg_ready, always ready); the user must write them only
// while no transfer is in flight; the block does not enforce it.
// Synchronous reset clears the preambles, the queue and the transfer state.
// ----------------------------------------------------------------------------
module tracker_frame_checker_core #(
    parameter int MAX_TRANSFER_BYTES = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [tfc_pkg::BYTE_W-1:0]              i_data_byte,
    input  logic                                    i_last_byte,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [tfc_pkg::KIND_W-1:0]              o_frame_kind,
    output logic [tfc_pkg::STAT_W-1:0]              o_check_status,
    output logic [$clog2(MAX_TRANSFER_BYTES+1)-1:0] o_byte_count,
    output logic [tfc_pkg::DECL_W-1:0]              o_declared_length,
    output logic [tfc_pkg::WORD_W-1:0]              o_frame_number,
    output logic [tfc_pkg::WORD_W-1:0]              o_sensor_count,
    output logic [tfc_pkg::CRC_W-1:0]               o_computed_crc,
    output logic [tfc_pkg::WORD_W-1:0]              o_carried_crc,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [tfc_pkg::WORD_W-1:0]              i_cfg_data
);
    import tfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRANSFER_BYTES + 2);
    localparam int ENT_W = $bits(t_entry);
    localparam int Q_W   = ENT_W + CNT_W;

    logic [WORD_W-1:0] r_pno_preamble;
    logic [WORD_W-1:0] r_cmd_preamble;

    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    t_entry           front_entry;
    t_entry           back_entry;
    logic [CNT_W-1:0] front_count;
    logic [CNT_W-1:0] back_count;
    logic [Q_W-1:0]   q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pno_preamble <= '0;
            r_cmd_preamble <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PNO_PREAMBLE: r_pno_preamble <= i_cfg_data;
                CFG_CMD_PREAMBLE: r_cmd_preamble <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tfc_front #(
        .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_entry     (front_entry),
        .o_count     (front_count)
    );

    tfc_queue #(
        .W(Q_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({front_count, front_entry}),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_out)
    );

    assign back_entry = t_entry'(q_out[ENT_W-1:0]);
    assign back_count = q_out[Q_W-1:ENT_W];

    tfc_back #(
        .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_entry           (back_entry),
        .i_count           (back_count),
        .o_pop             (pop),
        .i_pno_preamble    (r_pno_preamble),
        .i_cmd_preamble    (r_cmd_preamble),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_frame_kind      (o_frame_kind),
        .o_check_status    (o_check_status),
        .o_byte_count      (o_byte_count),
        .o_declared_length (o_declared_length),
        .o_frame_number    (o_frame_number),
        .o_sensor_count    (o_sensor_count),
        .o_computed_crc    (o_computed_crc),
        .o_carried_crc     (o_carried_crc)
    );

endmodule

### tb/tb_tracker_frame_checker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tracker_frame_checker_core: self-checking testbench of the frame checker
// Drives whole bulk transfers (good position and command frames, frames with
// a bad length or CRC, unknown preambles, short and oversized transfers and
// plain noise) into the core. A scoreboard works out each transfer's report
// byte by byte and checks every report field by field. Both channels idle in
// random bursts, and the receiver also holds off long enough to back up the
// input channel.
// ----------------------------------------------------------------------------
module tb_tracker_frame_checker_core;
    import tfc_pkg::*;

    localparam int          MAX_BYTES   = 1024;
    localparam int          CNT_W       = $clog2(MAX_BYTES + 1);
    localparam int unsigned PHASE_BYTES = 100;
    localparam int          HOLD_CYCLES = 120;
    localparam int          SETTLE      = 8;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          SHOWN_MAX   = 10;

    typedef enum {FLAW_NONE, FLAW_LENGTH, FLAW_CRC} t_frame_flaw;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic [DECL_W-1:0] declared;
        logic [WORD_W-1:0] frame_no;
        logic [WORD_W-1:0] sensors;
        logic [CRC_W-1:0]  crc;
        logic [WORD_W-1:0] carried;
    } t_frame_report;

    // Predicts the report of each transfer and matches it against the core.
    class frame_scoreboard;
        logic [WORD_W-1:0] pno_word;
        logic [WORD_W-1:0] cmd_word;
        logic [CRC_W-1:0]  crc_acc;
        int unsigned       seen;
        logic [BYTE_W-1:0] tail [TAIL_N];
        logic [WORD_W-1:0] pre_w;
        logic [WORD_W-1:0] len_w;
        logic [WORD_W-1:0] frm_w;
        logic [WORD_W-1:0] sns_w;
        t_frame_report     awaited[$];
        int unsigned       mismatches;
        int unsigned       reports;
        int unsigned       writes;
        int unsigned       kinds [3];
        int unsigned       len_fails;
        int unsigned       crc_fails;
        int unsigned       overruns;

        function new();
            pno_word   = '0;
            cmd_word   = '0;
            mismatches = 0;
            reports    = 0;
            writes     = 0;
            kinds      = '{0, 0, 0};
            len_fails  = 0;
            crc_fails  = 0;
            overruns   = 0;
            clear_transfer();
        endfunction

        static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] r;
            int k;
            r = c ^ {8'h00, b};
            for (k = 0; k < BYTE_W; k++) begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function void clear_transfer();
            crc_acc = '0;
            seen    = 0;
            tail    = '{8'h00, 8'h00, 8'h00, 8'h00};
            pre_w   = '0;
            len_w   = '0;
            frm_w   = '0;
            sns_w   = '0;
        endfunction

        function void set_preamble(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] v);
            writes++;
            if (idx == CFG_PNO_PREAMBLE) begin
                pno_word = v;
            end else if (idx == CFG_CMD_PREAMBLE) begin
                cmd_word = v;
            end
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            t_frame_report r;
            int unsigned   pos;
            int unsigned   sh;
            pos = seen;
            sh  = (pos % 4) * 8;
            if (pos < PRE_END) begin
                pre_w[sh +: 8] = b;
            end else if (pos < LEN_END) begin
                len_w[sh +: 8] = b;
            end else if (pos >= FRAME_START && pos < FRAME_END) begin
                frm_w[sh +: 8] = b;
            end else if (pos >= SENS_START && pos < SENS_END) begin
                sns_w[sh +: 8] = b;
            end
            // The byte falling out of the tail delay line is the one that enters the CRC.
            if (pos >= CRC_START) begin
                crc_acc = crc_step(crc_acc, tail[0]);
            end
            tail = '{tail[1], tail[2], tail[3], b};
            if (seen <= MAX_BYTES) begin
                seen++;
            end
            if (last) begin
                r.count    = (seen > MAX_BYTES) ? CNT_W'(MAX_BYTES) : CNT_W'(seen);
                r.declared = {1'b0, len_w} + LENGTH_BIAS;
                r.frame_no = frm_w;
                r.sensors  = sns_w;
                r.crc      = crc_acc;
                r.carried  = {tail[3], tail[2], tail[1], tail[0]};
                if (seen < MIN_FRAME_BYTES) begin
                    r.kind = KIND_UNKNOWN;
                end else if (pre_w == pno_word) begin
                    r.kind = KIND_PNO;
                end else if (pre_w == cmd_word) begin
                    r.kind = KIND_CMD;
                end else begin
                    r.kind = KIND_UNKNOWN;
                end
                if (r.kind == KIND_UNKNOWN) begin
                    r.status = STAT_OK;
                end else if (seen > MAX_BYTES || r.declared != DECL_W'(seen)) begin
                    r.status = STAT_LENGTH;
                end else if (r.carried != {16'h0000, crc_acc}) begin
                    r.status = STAT_CRC;
                end else begin
                    r.status = STAT_OK;
                end
                kinds[r.kind]++;
                if (r.status == STAT_LENGTH) len_fails++;
                if (r.status == STAT_CRC) crc_fails++;
                if (seen > MAX_BYTES) overruns++;
                awaited = {awaited, r};
                clear_transfer();
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= SHOWN_MAX) begin
                $display("[%0t] report %0d: %s", $time, reports, what);
            end
        endfunction

        function void compare_field(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                flag($sformatf("%s expected 0x%0h, got 0x%0h", name, e, a));
            end
        endfunction

        function void check_report(t_frame_report act);
            t_frame_report e;
            reports++;
            if (awaited.size() == 0) begin
                flag("report arrived with no transfer outstanding");
            end else begin
                e = awaited.pop_front();
                compare_field("frame_kind", 64'(e.kind), 64'(act.kind));
                compare_field("check_status", 64'(e.status), 64'(act.status));
                compare_field("byte_count", 64'(e.count), 64'(act.count));
                compare_field("declared_length", 64'(e.declared), 64'(act.declared));
                compare_field("frame_number", 64'(e.frame_no), 64'(act.frame_no));
                compare_field("sensor_count", 64'(e.sensors), 64'(act.sensors));
                compare_field("computed_crc", 64'(e.crc), 64'(act.crc));
                compare_field("carried_crc", 64'(e.carried), 64'(act.carried));
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]       i_data_byte = '0;
    logic                    i_last_byte = 1'b0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [WORD_W-1:0]       i_cfg_data  = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic                    o_cfg_ready;
    logic [KIND_W-1:0]       o_frame_kind;
    logic [STAT_W-1:0]       o_check_status;
    logic [CNT_W-1:0]        o_byte_count;
    logic [DECL_W-1:0]       o_declared_length;
    logic [WORD_W-1:0]       o_frame_number;
    logic [WORD_W-1:0]       o_sensor_count;
    logic [CRC_W-1:0]        o_computed_crc;
    logic [WORD_W-1:0]       o_carried_crc;

    frame_scoreboard   sb;
    logic [BYTE_W-1:0] xfer[$];
    logic [WORD_W-1:0] cur_pno     = '0;
    logic [WORD_W-1:0] cur_cmd     = '0;
    logic              idle_on     = 1'b0;
    logic              hold_ask    = 1'b0;
    int unsigned       bytes_sent  = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       backpressure = 0;
    int                n_list [6] = '{1, 2, 3, 4, 5, 7};

    tracker_frame_checker_core #(
        .MAX_TRANSFER_BYTES(MAX_BYTES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_kind     (o_frame_kind),
        .o_check_status   (o_check_status),
        .o_byte_count     (o_byte_count),
        .o_declared_length(o_declared_length),
        .o_frame_number   (o_frame_number),
        .o_sensor_count   (o_sensor_count),
        .o_computed_crc   (o_computed_crc),
        .o_carried_crc    (o_carried_crc),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Every transfer on the three channels is observed here, at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_frame_report got;
        logic          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_preamble(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_byte(i_data_byte, i_last_byte);
                moved = 1'b1;
            end
            if (i_in_valid && o_in_stall) begin
                backpressure++;
            end
            if (o_out_valid && !i_out_stall) begin
                got.kind     = o_frame_kind;
                got.status   = o_check_status;
                got.count    = o_byte_count;
                got.declared = o_declared_length;
                got.frame_no = o_frame_number;
                got.sensors  = o_sensor_count;
                got.crc      = o_computed_crc;
                got.carried  = o_carried_crc;
                sb.check_report(got);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // Report side: random stall bursts, or one long hold-off when asked for.
    always begin : report_side
        @(negedge i_clk);
        if (hold_ask) begin
            hold_ask = 1'b0;
            i_out_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge i_clk);
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("** tracker_frame_checker_core: FAILED **");
        $finish;
    end

    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        xfer = {xfer, b};
    endfunction

    function automatic void make_frame(input logic [WORD_W-1:0] pre, input int n,
                                       input t_frame_flaw flaw);
        logic [WORD_W-1:0] len;
        logic [CRC_W-1:0]  crc;
        int                i;
        len = WORD_W'(n - 8);
        if (flaw == FLAW_LENGTH) begin
            len = $urandom_range(0, 1) ? $urandom : len + $urandom_range(1, 9);
        end
        xfer.delete();
        for (i = 0; i < 4; i++) add_byte(pre[8*i +: 8]);
        for (i = 0; i < 4; i++) add_byte(len[8*i +: 8]);
        if (n < 12) begin
            while (xfer.size() < n) add_byte(8'($urandom));
        end else begin
            while (xfer.size() < n - 4) add_byte(8'($urandom));
            crc = '0;
            foreach (xfer[j]) crc = frame_scoreboard::crc_step(crc, xfer[j]);
            add_byte(crc[7:0]);
            add_byte(crc[15:8]);
            add_byte(8'h00);
            add_byte(8'h00);
            if (flaw == FLAW_CRC) begin
                i = n - 1 - $urandom_range(0, 3);
                xfer[i] = xfer[i] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
    endfunction

    function automatic void make_bytes(input int n, input logic [BYTE_W-1:0] v,
                                       input bit scramble);
        xfer.delete();
        while (xfer.size() < n) add_byte(scramble ? 8'($urandom) : v);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_xfer();
        foreach (xfer[j]) send_byte(xfer[j], j == xfer.size() - 1);
    endtask

    // Stops offering bytes, waits until every report is in, and then lets the core settle.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_preamble(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_preambles(input logic [WORD_W-1:0] pno, input logic [WORD_W-1:0] cmd);
        wait_drained();
        write_preamble(CFG_PNO_PREAMBLE, pno);
        write_preamble(CFG_CMD_PREAMBLE, cmd);
        cur_pno = pno;
        cur_cmd = cmd;
    endtask

    task automatic random_transfer();
        int          pick;
        int          n;
        t_frame_flaw flaw;
        pick = $urandom_range(0, 99);
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(12, 40);
        flaw = FLAW_NONE;
        if (pick >= 60 && pick < 66) flaw = FLAW_LENGTH;
        if (pick >= 66 && pick < 72) flaw = FLAW_CRC;
        if (pick < 72) begin
            make_frame($urandom_range(0, 1) ? cur_pno : cur_cmd, n, flaw);
        end else if (pick < 85) begin
            make_frame($urandom, $urandom_range(8, 40), FLAW_NONE);
        end else begin
            make_bytes($urandom_range(1, 40), 8'h00, 1'b1);
        end
        send_xfer();
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) random_transfer();
    endtask

    initial begin : stimulus
        int n;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Both preambles still at their reset value: the position preamble wins.
        make_frame('0, 24, FLAW_NONE);
        send_xfer();
        set_preambles(32'hFFFF_FFFF, 32'h0000_0000);
        make_frame(32'hFFFF_FFFF, 28, FLAW_NONE);
        send_xfer();
        make_frame(32'h0000_0000, 24, FLAW_NONE);
        send_xfer();
        make_frame(32'hA5A5_5A5A, 20, FLAW_NONE);
        send_xfer();
        make_frame(32'hFFFF_FFFF, 16, FLAW_LENGTH);
        send_xfer();
        make_frame(32'h0000_0000, 30, FLAW_CRC);
        send_xfer();
        // Short transfers, including ones that never fill the tail delay line.
        foreach (n_list[k]) begin
            make_bytes(n_list[k], 8'h00, 1'b1);
            send_xfer();
        end
        make_frame(32'hFFFF_FFFF, 8, FLAW_NONE);
        send_xfer();
        // Header words cut off by the end of the transfer.
        make_frame(32'hFFFF_FFFF, 14, FLAW_NONE);
        send_xfer();
        make_bytes(24, 8'hFF, 1'b0);
        send_xfer();
        make_bytes(12, 8'h00, 1'b0);
        send_xfer();
        // One byte past the largest legal transfer: the count saturates.
        make_frame(32'h0000_0000, MAX_BYTES + 1, FLAW_NONE);
        send_xfer();

        set_preambles($urandom, $urandom);
        idle_on = 1'b1;
        random_phase(PHASE_BYTES);

        // Equal preambles, then a long receiver hold-off with the sender pushing on.
        n = $urandom;
        set_preambles(n, n);
        hold_ask = 1'b1;
        repeat (10) begin
            make_frame($urandom_range(0, 1) ? cur_pno : $urandom, 12, FLAW_NONE);
            send_xfer();
        end

        set_preambles(32'h0000_0000, 32'hFFFF_FFFF);
        idle_on = 1'b0;
        random_phase(PHASE_BYTES / 3);
        idle_on = 1'b1;
        random_phase(PHASE_BYTES - PHASE_BYTES / 3);

        set_preambles($urandom, $urandom);
        idle_on = 1'b0;
        random_phase(PHASE_BYTES);

        wait_drained();
        if (sb.pending() != 0) begin
            sb.flag($sformatf("%0d reports never arrived", sb.pending()));
        end
        $display("run covered %0d bytes, %0d reports (%0d position, %0d command, %0d unknown)",
                 bytes_sent, sb.reports, sb.kinds[KIND_PNO], sb.kinds[KIND_CMD],
                 sb.kinds[KIND_UNKNOWN]);
        $display("%0d length and %0d crc failures, %0d overruns, %0d preamble writes, %0d %s",
                 sb.len_fails, sb.crc_fails, sb.overruns, sb.writes, backpressure,
                 "cycles of input backpressure");
        if (sb.mismatches == 0) begin
            $display("** tracker_frame_checker_core: PASSED **");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("** tracker_frame_checker_core: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
sv/tfc_pkg.sv
sv/tfc_queue.sv
sv/tfc_front.sv
sv/tfc_back.sv
sv/tracker_frame_checker_core.sv
tb/tb_tracker_frame_checker_core.sv
